// File: rtl/core/avc_pkg.sv
package avc_pkg;

    localparam int COORD_W  = 5;
    localparam int SIZE_W   = 6;
    localparam int ISO_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int MASK_W   = 8;
    localparam int VIDX_W   = 15;
    localparam int CORNERS  = 8;
    localparam int CNT_W    = 3;

    localparam logic OP_WRITE    = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    typedef enum logic [1:0] {
        REG_ISO_LEVEL = 2'd0,
        REG_SIZE_X    = 2'd1,
        REG_SIZE_Y    = 2'd2,
        REG_SIZE_Z    = 2'd3
    } cfg_reg_t;

    // per-corner unit steps along each axis, bit n for corner n
    localparam logic [CORNERS-1:0] CORNER_DI = 8'b0110_0110;
    localparam logic [CORNERS-1:0] CORNER_DJ = 8'b1100_1100;
    localparam logic [CORNERS-1:0] CORNER_DK = 8'b1111_0000;

    localparam logic [MASK_W-1:0] MASK_NONE = '0;
    localparam logic [MASK_W-1:0] MASK_ALL  = '1;

endpackage

// File: rtl/core/active_voxel_classifier.sv
// Marching-cubes active voxel classifier over a signed-distance volume held in an
// on-chip sample store of MAX_RES^3 words of SAMPLE_BITS bits. A write beat (tuser 0)
// stores one Q8.8 sample at vertex (i,j,k); a classify beat (tuser 1) reads the eight
// corners of voxel (i,j,k) and returns the below-iso mask, the active flag and the
// linear voxel index. Out-of-range coordinates return a result with tuser (range
// error) set and zero data; an in-range write returns nothing. The store is single
// ported: a classify holds it for its eight corner reads, one corner read per cycle
// unless the output stalls, and no new voxel is taken before the last one's reads are
// done; writes run at one per cycle unless the output stalls. The store is not
// cleared after reset: a voxel must only be classified once all of its corners have
// been written. The user is to write configuration only while the block is idle;
// the block itself does not enforce this.
module active_voxel_classifier #(
    parameter int MAX_RES     = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // grid_i[4:0], grid_j[9:5], grid_k[14:10], sample_value[30:15], zero[31]
    input  logic [31:0] s_axis_tdata,
    // operation[0]
    input  logic [0:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // active[0], below_mask[8:1], voxel_index[23:9]
    output logic [23:0] m_axis_tdata,
    // range_error[0]
    output logic [0:0]  m_axis_tuser
);

    localparam int CW    = avc_pkg::COORD_W;
    localparam int SB    = SAMPLE_BITS;
    localparam int SW    = $clog2(MAX_RES + 1);
    localparam int TW    = CW + SW + 1;
    localparam int PW0   = CW + 2 * SW + 2;
    localparam int PW    = (PW0 > avc_pkg::VIDX_W) ? PW0 : avc_pkg::VIDX_W;
    localparam int DEPTH = MAX_RES * MAX_RES * MAX_RES;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = avc_pkg::VIDX_W;
    localparam int MW    = avc_pkg::MASK_W;
    localparam int NW    = avc_pkg::CNT_W;

    // configuration
    logic signed [avc_pkg::ISO_W-1:0]  iso_reg;
    logic        [avc_pkg::SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic        [SW-1:0]              rx, ry, rz;
    logic        [AW-1:0]              ryrz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iso_reg    <= '0;
            size_x_reg <= 6'd32;
            size_y_reg <= 6'd32;
            size_z_reg <= 6'd32;
        end else if (cfg_wen) begin
            case (avc_pkg::cfg_reg_t'(cfg_index))
                avc_pkg::REG_ISO_LEVEL: iso_reg    <= cfg_wdata;
                avc_pkg::REG_SIZE_X:    size_x_reg <= cfg_wdata[avc_pkg::SIZE_W-1:0];
                avc_pkg::REG_SIZE_Y:    size_y_reg <= cfg_wdata[avc_pkg::SIZE_W-1:0];
                avc_pkg::REG_SIZE_Z:    size_z_reg <= cfg_wdata[avc_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes clamped to [2, MAX_RES]
    always_comb begin
        if (size_x_reg < 6'd2) begin
            rx = SW'(2);
        end else if (32'(size_x_reg) > MAX_RES) begin
            rx = SW'(MAX_RES);
        end else begin
            rx = SW'(size_x_reg);
        end
        if (size_y_reg < 6'd2) begin
            ry = SW'(2);
        end else if (32'(size_y_reg) > MAX_RES) begin
            ry = SW'(MAX_RES);
        end else begin
            ry = SW'(size_y_reg);
        end
        if (size_z_reg < 6'd2) begin
            rz = SW'(2);
        end else if (32'(size_z_reg) > MAX_RES) begin
            rz = SW'(MAX_RES);
        end else begin
            rz = SW'(size_z_reg);
        end
    end

    // plane stride, settles long before any beat needs it
    always_ff @(posedge aclk) begin
        ryrz_reg <= AW'(ry) * AW'(rz);
    end

    // pipeline control
    logic adv;
    logic seq_take;
    logic s2_ready;

    // stage 1: input register
    logic                s1_valid_reg;
    logic                s1_op_reg;
    logic [CW-1:0]       s1_i_reg, s1_j_reg, s1_k_reg;
    logic signed [15:0]  s1_sample_reg;

    assign s_axis_tready = !s1_valid_reg || s2_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            s1_op_reg     <= s_axis_tuser[0];
            s1_i_reg      <= s_axis_tdata[4:0];
            s1_j_reg      <= s_axis_tdata[9:5];
            s1_k_reg      <= s_axis_tdata[14:10];
            s1_sample_reg <= s_axis_tdata[30:15];
        end
    end

    // stage 1 logic: range check and first multiply
    logic               s1_classify;
    logic               s1_err;
    logic [TW-1:0]      s1_t1, s1_v1;
    logic signed [31:0] s1_sample_sx;

    assign s1_classify  = (s1_op_reg == avc_pkg::OP_CLASSIFY);
    assign s1_sample_sx = 32'(s1_sample_reg);

    always_comb begin
        if (s1_classify) begin
            s1_err = (32'(s1_i_reg) >= 32'(rx) - 32'd1) ||
                     (32'(s1_j_reg) >= 32'(ry) - 32'd1) ||
                     (32'(s1_k_reg) >= 32'(rz) - 32'd1);
        end else begin
            s1_err = (32'(s1_i_reg) >= 32'(rx)) ||
                     (32'(s1_j_reg) >= 32'(ry)) ||
                     (32'(s1_k_reg) >= 32'(rz));
        end
        s1_t1 = TW'(s1_i_reg) * TW'(ry) + TW'(s1_j_reg);
        s1_v1 = TW'(s1_i_reg) * TW'(ry - 1'b1) + TW'(s1_j_reg);
    end

    // stage 2
    logic          s2_valid_reg;
    logic          s2_classify_reg;
    logic          s2_err_reg;
    logic [TW-1:0] s2_t1_reg, s2_v1_reg;
    logic [CW-1:0] s2_k_reg;
    logic [SB-1:0] s2_wdata_reg;

    assign s2_ready = !s2_valid_reg || seq_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_classify_reg <= s1_classify;
            s2_err_reg      <= s1_err;
            s2_t1_reg       <= s1_t1;
            s2_v1_reg       <= s1_v1;
            s2_k_reg        <= s1_k_reg;
            s2_wdata_reg    <= s1_sample_sx[SB-1:0];
        end
    end

    // stage 2 logic: base address and voxel index
    logic [PW-1:0] s2_addr_full, s2_vidx_full;

    always_comb begin
        s2_addr_full = PW'(s2_t1_reg) * PW'(rz) + PW'(s2_k_reg);
        s2_vidx_full = PW'(s2_v1_reg) * PW'(rz - 1'b1) + PW'(s2_k_reg);
    end

    // stage 3: corner sequencer, owns the store port
    logic          s3_valid_reg;
    logic          s3_classify_reg;
    logic          s3_err_reg;
    logic [AW-1:0] s3_base_reg;
    logic [VW-1:0] s3_vidx_reg;
    logic [SB-1:0] s3_wdata_reg;
    logic [NW-1:0] s3_cnt_reg, s3_cnt_next;
    logic          s3_multi;
    logic          s3_last;
    logic [AW-1:0] s3_addr;

    assign s3_multi = s3_classify_reg && !s3_err_reg;
    assign s3_last  = !s3_multi || (s3_cnt_reg == NW'(avc_pkg::CORNERS - 1));
    assign seq_take = adv && (!s3_valid_reg || s3_last);

    always_comb begin
        s3_addr = s3_base_reg
                + (avc_pkg::CORNER_DI[s3_cnt_reg] ? ryrz_reg : '0)
                + (avc_pkg::CORNER_DJ[s3_cnt_reg] ? AW'(rz) : '0)
                + AW'(avc_pkg::CORNER_DK[s3_cnt_reg]);
        if (seq_take) begin
            s3_cnt_next = '0;
        end else if (adv && s3_valid_reg) begin
            s3_cnt_next = s3_cnt_reg + 1'b1;
        end else begin
            s3_cnt_next = s3_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s3_cnt_reg   <= '0;
        end else begin
            s3_cnt_reg <= s3_cnt_next;
            if (seq_take) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_take && s2_valid_reg) begin
            s3_classify_reg <= s2_classify_reg;
            s3_err_reg      <= s2_err_reg;
            s3_base_reg     <= s2_addr_full[AW-1:0];
            s3_vidx_reg     <= s2_vidx_full[VW-1:0];
            s3_wdata_reg    <= s2_wdata_reg;
        end
    end

    // sample store, single port
    logic [SB-1:0] store_mem [DEPTH];
    logic [SB-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (adv && s3_valid_reg && !s3_classify_reg && !s3_err_reg) begin
            store_mem[s3_base_reg] <= s3_wdata_reg;
        end else if (adv && s3_valid_reg && s3_multi) begin
            rdata_reg <= store_mem[s3_addr];
        end
    end

    // stage 4: compare and collect the mask
    logic          s4_valid_reg;
    logic          s4_classify_reg;
    logic          s4_err_reg;
    logic          s4_last_reg;
    logic [NW-1:0] s4_corner_reg;
    logic [VW-1:0] s4_vidx_reg;
    logic [MW-1:0] mask_acc_reg;
    logic [MW-1:0] mask_now;
    logic          below;
    logic          s4_emit;
    logic          s4_good;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_classify_reg <= s3_classify_reg;
            s4_err_reg      <= s3_err_reg;
            s4_last_reg     <= s3_last;
            s4_corner_reg   <= s3_cnt_reg;
            s4_vidx_reg     <= s3_vidx_reg;
        end
    end

    assign below   = $signed(rdata_reg) < iso_reg;
    assign s4_good = s4_classify_reg && !s4_err_reg;
    assign s4_emit = s4_valid_reg && s4_last_reg && (s4_err_reg || s4_classify_reg);

    always_comb begin
        mask_now = ((s4_corner_reg == '0) ? avc_pkg::MASK_NONE : mask_acc_reg)
                 | (MW'(below) << s4_corner_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv && s4_valid_reg && s4_good) begin
            mask_acc_reg <= mask_now;
        end
    end

    // output register
    logic          m_valid_reg, m_valid_next;
    logic          m_active_reg;
    logic [MW-1:0] m_mask_reg;
    logic [VW-1:0] m_vidx_reg;
    logic          m_err_reg;

    // only a result that cannot leave holds the sequencer
    assign adv = !(s4_emit && m_valid_reg && !m_axis_tready);

    always_comb begin
        if (adv && s4_emit) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s4_emit) begin
            m_err_reg    <= s4_err_reg;
            m_active_reg <= s4_good && (mask_now != avc_pkg::MASK_NONE)
                                    && (mask_now != avc_pkg::MASK_ALL);
            m_mask_reg   <= s4_good ? mask_now : avc_pkg::MASK_NONE;
            m_vidx_reg   <= s4_good ? s4_vidx_reg : '0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_vidx_reg, m_mask_reg, m_active_reg};
    assign m_axis_tuser  = m_err_reg;

    // checks
    a_single_beat_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg && !s3_multi |-> s3_cnt_reg == '0)
        else $error("corner count moved on a single-beat item");

    a_stall_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(s3_cnt_reg))
        else $error("corner count moved during an output stall");

    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_valid_reg && s4_last_reg && s4_good |-> s4_corner_reg == NW'(avc_pkg::CORNERS - 1))
        else $error("classify result emitted before the last corner");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("range error result carries data");

endmodule
